>>> rtl/assert_macros.svh
// Assertion macros shared by the step interpolator RTL.
// Included by any module that carries concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define MSI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property failed");
// A condition that must never be seen outside reset.
`define MSI_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define MSI_ASSERT(label, clk, rst, prop)
`define MSI_NEVER(label, clk, rst, expr)
`endif
`endif

>>> rtl/msi_pkg.sv
// Shared types and constants of the multi-axis step interpolator.
// No dependencies; imported by the interfaces and all RTL modules.
package msi_pkg;

   localparam int AXIS_W  = 12;
   localparam int STEP_W  = 8;
   localparam int DIFF_W  = AXIS_W + 1;
   localparam int PROD_W  = AXIS_W + STEP_W;
   localparam int QUOT_W  = STEP_W;
   localparam int INC_W   = QUOT_W + 1;
   localparam int CNT_W   = 6;
   localparam int DIV_CYCLES = QUOT_W;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic [AXIS_W-1:0] CENTER_POS      = 12'd1500;
   localparam logic [STEP_W-1:0] STEP_RESET      = 8'd50;
   localparam logic [STEP_W-1:0] STEP_FLOOR      = 8'd32;
   localparam logic [CNT_W-1:0]  MAX_INC_RESULTS = 6'd63;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAX,
      ST_DIV,
      ST_STEP,
      ST_ZERO
   } seq_state_type;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic add_inc;
      logic set_tgt;
   } lane_ctl_type;

endpackage

>>> rtl/msi_req_if.sv
// Request channel of the step interpolator: one target per axis.
// Depends on msi_pkg for the axis width.
interface msi_req_if #(parameter int NUM_AXES = 5) ();
   import msi_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [NUM_AXES*AXIS_W-1:0] target;

   modport source (output valid, output target, input ready);
   modport sink (input valid, input target, output ready);
endinterface

>>> rtl/msi_rsp_if.sv
// Result channel of the step interpolator: drive per axis and a last-step flag.
// Depends on msi_pkg for the axis width.
interface msi_rsp_if #(parameter int NUM_AXES = 5) ();
   import msi_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [NUM_AXES*AXIS_W-1:0] drive;
   logic                       last_step;

   modport source (output valid, output drive, output last_step, input ready);
   modport sink (input valid, input drive, input last_step, output ready);
endinterface

>>> rtl/msi_csr_if.sv
// Configuration write channel of the step interpolator: the max_step register.
// Depends on msi_pkg for the register width.
interface msi_csr_if ();
   import msi_pkg::*;

   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] max_step;

   modport source (output valid, output max_step, input ready);
   modport sink (input valid, input max_step, output ready);
endinterface

>>> rtl/multi_axis_step_interpolator_top.sv
// Multi-axis step interpolator: top level with the move sequencer and result register.
// Depends on msi_pkg, the three channel interfaces, msi_lane, msi_merge, assert_macros.svh.
//
// Usage:
// A request on req_chan carries one target pulse width per axis. The block
// answers with a burst of results on rsp_chan, each holding a drive value
// per axis; last_step marks the final result of the move. csr_chan is always ready;
// the user writes max_step only while the block is idle; the block does not enforce it.
// Timing: a request is taken only when the sequencer is idle. In the next
// cycle the lanes have their move magnitudes and the merge stage registers the
// largest one; the per-lane dividers then work out the increments.
// The first result follows the division (a move with no motion leaves it
// early and gives a single last result), and further results follow one per
// cycle while rsp_chan.ready stays high.
// The result register holds its contents while the receiver stalls, and
// the sequencer waits with it; no result is dropped or repeated.
// Reset puts every axis position at 1500, max_step at 50, and empties the
// result register.
`include "assert_macros.svh"

module multi_axis_step_interpolator_top #(
   parameter int NUM_AXES = 5
) (
   input  logic        clock,
   input  logic        reset,
   msi_req_if.sink     req_chan,
   msi_rsp_if.source   rsp_chan,
   msi_csr_if.sink     csr_chan
);
   import msi_pkg::*;

   seq_state_type state_ff, state_in;

   logic [STEP_W-1:0]    max_step_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [STEP_W-1:0]    step_eff;
   logic [AXIS_W-1:0]    rem_ff;
   logic [AXIS_W-1:0]    rem_next;
   logic [CNT_W-1:0]     n_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   logic                       rsp_valid_ff;
   logic [NUM_AXES*AXIS_W-1:0] drive_ff;
   logic                       last_ff;

   lane_ctl_type                    lane_ctl;
   logic [NUM_AXES-1:0][AXIS_W-1:0] abs_moves;
   logic [NUM_AXES*AXIS_W-1:0]      step_pos_all;
   logic [NUM_AXES*AXIS_W-1:0]      tgt_all;
   logic [AXIS_W-1:0]               big;

   logic req_accept;
   logic out_free;
   logic take_inc;
   logic rsp_load;
   logic out_last_in;
   logic out_sel_inc;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign step_eff   = (max_step_ff < STEP_FLOOR) ? STEP_FLOOR : max_step_ff;
   assign rem_next   = rem_ff - AXIS_W'(step_ff);
   assign take_inc   = (rem_ff >= AXIS_W'(step_ff)) && (n_ff != MAX_INC_RESULTS);

   genvar g;
   generate
      for (g = 0; g < NUM_AXES; g++) begin : g_lane
         msi_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .ctl      (lane_ctl),
            .target   (req_chan.target[g*AXIS_W +: AXIS_W]),
            .step     (step_ff),
            .big      (big),
            .abs_move (abs_moves[g]),
            .step_pos (step_pos_all[g*AXIS_W +: AXIS_W]),
            .tgt_pos  (tgt_all[g*AXIS_W +: AXIS_W])
         );
      end
   endgenerate

   msi_merge #(.NUM_AXES(NUM_AXES)) u_merge (
      .clock     (clock),
      .load      (state_ff == ST_MAX),
      .abs_moves (abs_moves),
      .big       (big)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MAX;
            end
         end
         ST_MAX: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (big == '0) begin
               state_in = ST_ZERO;
            end else if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (out_free && (!take_inc || rem_next == '0)) begin
               state_in = ST_IDLE;
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      lane_ctl    = '0;
      rsp_load    = 1'b0;
      out_last_in = 1'b0;
      out_sel_inc = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            lane_ctl.load = req_chan.valid;
         end
         ST_MAX: begin
            lane_ctl.div_init = 1'b1;
         end
         ST_DIV: begin
            lane_ctl.div_step = 1'b1;
         end
         ST_STEP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               // An increment that lands the count on zero closes the move
               // itself; otherwise the move ends with a jump to the targets.
               if (take_inc) begin
                  out_sel_inc      = 1'b1;
                  lane_ctl.add_inc = 1'b1;
                  out_last_in      = (rem_next == '0);
                  lane_ctl.set_tgt = (rem_next == '0);
               end else begin
                  out_last_in      = 1'b1;
                  lane_ctl.set_tgt = 1'b1;
               end
            end
         end
         ST_ZERO: begin
            if (out_free) begin
               rsp_load         = 1'b1;
               out_last_in      = 1'b1;
               lane_ctl.set_tgt = 1'b1;
            end
         end
         default: begin
            lane_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_step_ff  <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid && csr_chan.ready) begin
            max_step_ff <= csr_chan.max_step;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         step_ff <= step_eff;
      end
      if (state_ff == ST_MAX) begin
         cnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         rem_ff <= big;
         n_ff   <= '0;
      end else if (state_ff == ST_STEP && out_free && take_inc) begin
         rem_ff <= rem_next;
         n_ff   <= n_ff + CNT_W'(1);
      end
      if (rsp_load) begin
         drive_ff <= out_sel_inc ? step_pos_all : tgt_all;
         last_ff  <= out_last_in;
      end
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign csr_chan.ready     = 1'b1;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.drive     = drive_ff;
   assign rsp_chan.last_step = last_ff;

   `MSI_ASSERT(a_last_ends_move, clock, reset, rsp_load && out_last_in |=> state_ff == ST_IDLE)
   `MSI_NEVER(a_step_count_live, clock, reset, state_ff == ST_STEP && rem_ff == '0)
   `MSI_NEVER(a_no_overwrite, clock, reset, rsp_load && rsp_valid_ff && !rsp_chan.ready)
   `MSI_NEVER(a_idle_no_result, clock, reset, req_chan.ready && rsp_load)

endmodule

>>> rtl/msi_lane.sv
// One axis lane: stored position, move magnitude, bit-serial increment divider.
// Depends on msi_pkg; instantiated once per axis by the top level.
module msi_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  msi_pkg::lane_ctl_type         ctl,
   input  logic [msi_pkg::AXIS_W-1:0]    target,
   input  logic [msi_pkg::STEP_W-1:0]    step,
   input  logic [msi_pkg::AXIS_W-1:0]    big,
   output logic [msi_pkg::AXIS_W-1:0]    abs_move,
   output logic [msi_pkg::AXIS_W-1:0]    step_pos,
   output logic [msi_pkg::AXIS_W-1:0]    tgt_pos
);
   import msi_pkg::*;

   logic [AXIS_W-1:0] pos_ff, pos_in;
   logic [AXIS_W-1:0] tgt_ff;
   logic              neg_ff;
   logic [AXIS_W-1:0] absm_ff;
   logic [AXIS_W-1:0] prem_ff, prem_in;
   logic [QUOT_W-1:0] lo_ff, lo_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;

   logic [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0] abs_full;
   logic [PROD_W-1:0] prod_full;
   logic [DIFF_W-1:0] trial;
   logic              fits;
   logic [INC_W-1:0]  inc_mag;
   logic [INC_W-1:0]  inc;

   assign diff     = {1'b0, target} - {1'b0, pos_ff};
   assign abs_full = diff[DIFF_W-1] ? (DIFF_W'(0) - diff) : diff;
   assign prod_full = PROD_W'(absm_ff) * PROD_W'(step);

   // Restoring division: the quotient never exceeds step, so the upper
   // product bits start below big and eight trial subtracts finish it.
   assign trial   = {prem_ff, lo_ff[QUOT_W-1]};
   assign fits    = trial >= {1'b0, big};
   assign prem_in = fits ? AXIS_W'(trial - {1'b0, big}) : AXIS_W'(trial);
   assign lo_in   = {lo_ff[QUOT_W-2:0], 1'b0};
   assign quot_in = {quot_ff[QUOT_W-2:0], fits};

   assign inc_mag  = {1'b0, quot_ff};
   assign inc      = neg_ff ? (INC_W'(0) - inc_mag) : inc_mag;
   assign step_pos = pos_ff + {{(AXIS_W-INC_W){inc[INC_W-1]}}, inc};

   always_comb begin
      pos_in = pos_ff;
      if (ctl.set_tgt) begin
         pos_in = tgt_ff;
      end else if (ctl.add_inc) begin
         pos_in = step_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= CENTER_POS;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         tgt_ff  <= target;
         neg_ff  <= diff[DIFF_W-1];
         absm_ff <= abs_full[AXIS_W-1:0];
      end
      if (ctl.div_init) begin
         prem_ff <= prod_full[PROD_W-1:QUOT_W];
         lo_ff   <= prod_full[QUOT_W-1:0];
         quot_ff <= '0;
      end else if (ctl.div_step) begin
         prem_ff <= prem_in;
         lo_ff   <= lo_in;
         quot_ff <= quot_in;
      end
   end

   assign abs_move = absm_ff;
   assign tgt_pos  = tgt_ff;

endmodule

>>> rtl/msi_merge.sv
// Merge stage: registers the largest move magnitude over all axis lanes.
// Depends on msi_pkg; fed by the msi_lane instances.
module msi_merge #(
   parameter int NUM_AXES = 5
) (
   input  logic                                       clock,
   input  logic                                       load,
   input  logic [NUM_AXES-1:0][msi_pkg::AXIS_W-1:0]   abs_moves,
   output logic [msi_pkg::AXIS_W-1:0]                 big
);
   import msi_pkg::*;

   logic [AXIS_W-1:0] big_ff, big_in;

   always_comb begin
      big_in = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (abs_moves[i] > big_in) begin
            big_in = abs_moves[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         big_ff <= big_in;
      end
   end

   assign big = big_ff;

endmodule
